[rtl/hca_pkg.sv]
// Shared types and constants for the Hilbert coordinates-to-index block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hca_pkg;

    // Parameter ranges and defaults
    localparam int DIMS_LIMIT   = 8;
    localparam int BITS_LIMIT   = 32;
    localparam int MAX_DIMS_DEF = 4;
    localparam int MAX_BITS_DEF = 16;

    // Fixed field widths
    localparam int COORD_W    = 16;
    localparam int NUM_COORDS = 4;
    localparam int INDEX_W    = 64;
    localparam int DIM_REG_W  = 3;
    localparam int BIT_REG_W  = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Widths of the effective (clamped) configuration
    localparam int DIM_CNT_W = $clog2(DIMS_LIMIT + 1);
    localparam int BIT_CNT_W = $clog2(BITS_LIMIT + 1);

    localparam logic [DIM_REG_W-1:0] DIM_RESET  = DIM_REG_W'(2);
    localparam logic [BIT_REG_W-1:0] BITS_RESET = BIT_REG_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMENSION_COUNT = 1'b0,
        REG_BITS_PER_AXIS   = 1'b1
    } t_cfg_reg;

    // Effective configuration seen by every stage
    typedef struct packed {
        logic                 one_dim;
        logic [DIM_CNT_W-1:0] dims;
        logic [BIT_CNT_W-1:0] bits;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/hca_prep.sv]
// Entry stage: masks each coordinate to the active width and left-aligns it.
// Depends on hca_pkg.
`default_nettype none

module hca_prep import hca_pkg::*; #(
    parameter int MAX_DIMS = MAX_DIMS_DEF,
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_accept,
    input  wire logic [COORD_W-1:0]                 i_coord_x,
    input  wire logic [COORD_W-1:0]                 i_coord_y,
    input  wire logic [COORD_W-1:0]                 i_coord_z,
    input  wire logic [COORD_W-1:0]                 i_coord_w,
    input  wire t_cfg                               i_cfg,
    output logic                                    o_valid,
    output logic [MAX_DIMS-1:0][MAX_BITS-1:0]       o_coords
);

    logic [NUM_COORDS-1:0][COORD_W-1:0]  w_in;
    logic [MAX_DIMS-1:0][MAX_BITS-1:0]   w_raw;
    logic [MAX_DIMS-1:0][MAX_BITS-1:0]   w_aligned;
    logic [BIT_CNT_W-1:0]                w_shamt;

    logic                                r_valid;
    logic [MAX_DIMS-1:0][MAX_BITS-1:0]   r_coords;

    assign w_in = {i_coord_w, i_coord_z, i_coord_y, i_coord_x};

    // Axes beyond the inputs and bits beyond the input width read as zero
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_axis
        for (genvar i = 0; i < MAX_BITS; i++) begin : g_bit
            if (d < NUM_COORDS && i < COORD_W) begin : g_live
                assign w_raw[d][i] = w_in[d][i];
            end else begin : g_zero
                assign w_raw[d][i] = 1'b0;
            end
        end
    end

    // Top level of the item lands on bit MAX_BITS-1; bits above b drop out
    assign w_shamt = BIT_CNT_W'(MAX_BITS) - i_cfg.bits;

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (DIM_CNT_W'(d) < i_cfg.dims) begin
                w_aligned[d] = w_raw[d] << w_shamt;
            end else begin
                w_aligned[d] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coords <= w_aligned;
    end

    assign o_valid  = r_valid;
    assign o_coords = r_coords;

endmodule

`default_nettype wire

[rtl/hca_level.sv]
// One curve level: Gray step, reflect/rotate, state update, and emission of
// the level's final index bits with the running top-down parity. Uses hca_pkg.
`default_nettype none

module hca_level import hca_pkg::*; #(
    parameter int MAX_DIMS = MAX_DIMS_DEF,
    parameter int MAX_BITS = MAX_BITS_DEF,
    parameter int LEVEL    = 0
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire t_cfg                                   i_cfg,
    input  wire logic                                   i_valid,
    input  wire logic [MAX_DIMS-1:0][MAX_BITS-1:0]      i_coords,
    input  wire logic [$clog2(MAX_DIMS)-1:0]            i_rot,
    input  wire logic [MAX_DIMS-1:0]                    i_flip,
    input  wire logic                                   i_par,
    input  wire logic [INDEX_W-1:0]                     i_idx,
    output logic                                        o_valid,
    output logic [MAX_DIMS-1:0][MAX_BITS-1:0]           o_coords,
    output logic [$clog2(MAX_DIMS)-1:0]                 o_rot,
    output logic [MAX_DIMS-1:0]                         o_flip,
    output logic                                        o_par,
    output logic [INDEX_W-1:0]                          o_idx
);

    localparam int ROT_W = $clog2(MAX_DIMS);
    localparam int SUM_W = $clog2(2 * MAX_DIMS);

    function automatic logic [SUM_W-1:0] wrap_mod(input logic [SUM_W-1:0] s,
                                                  input logic [SUM_W-1:0] m);
        return (s >= m) ? (s - m) : s;
    endfunction

    logic [MAX_DIMS-1:0]   w_raw;
    logic [MAX_DIMS-1:0]   w_above;
    logic [MAX_DIMS-1:0]   w_pre;
    logic [MAX_DIMS-1:0]   w_grp;
    logic [MAX_DIMS-1:0]   w_top_flip;
    logic [MAX_DIMS-1:0]   w_adj;
    logic [MAX_DIMS-1:0]   w_fin;
    logic [SUM_W-1:0]      w_dims;
    logic                  w_found;
    logic [SUM_W-1:0]      w_pos;
    logic [SUM_W-1:0]      w_adv;
    logic                  w_active;

    logic [ROT_W-1:0]      n_rot;
    logic [MAX_DIMS-1:0]   n_flip;
    logic                  n_par;
    logic [INDEX_W-1:0]    n_idx;

    logic                                   r_valid;
    logic [MAX_DIMS-1:0][MAX_BITS-1:0]      r_coords;
    logic [ROT_W-1:0]                       r_rot;
    logic [MAX_DIMS-1:0]                    r_flip;
    logic                                   r_par;
    logic [INDEX_W-1:0]                     r_idx;

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_row
        assign w_raw[d] = i_coords[d][MAX_BITS-1-LEVEL];
        if (LEVEL == 0) begin : g_top
            assign w_above[d] = 1'b0;
        end else begin : g_lower
            assign w_above[d] = i_coords[d][MAX_BITS-LEVEL];
        end
    end

    assign w_dims   = SUM_W'(i_cfg.dims);
    assign w_active = BIT_CNT_W'(LEVEL) < i_cfg.bits;

    // Gray step across levels, then reflection by the carried flip mask
    assign w_pre = i_flip ^ w_raw ^ w_above;

    always_comb begin
        for (int j = 0; j < MAX_DIMS; j++) begin
            if (SUM_W'(j) < w_dims) begin
                w_grp[j] = w_pre[ROT_W'(wrap_mod(SUM_W'(j) + SUM_W'(i_rot), w_dims))];
            end else begin
                w_grp[j] = 1'b0;
            end
        end
    end

    // Lowest set bit of the group, below its top bit
    always_comb begin
        w_found = 1'b0;
        w_pos   = '0;
        for (int j = MAX_DIMS - 2; j >= 0; j--) begin
            if (w_grp[j] && (SUM_W'(j + 1) < w_dims)) begin
                w_found = 1'b1;
                w_pos   = SUM_W'(j);
            end
        end
    end

    assign w_adv  = w_found ? (w_pos + SUM_W'(2)) : SUM_W'(1);
    assign n_rot  = ROT_W'(wrap_mod(SUM_W'(i_rot) + w_adv, w_dims));
    assign n_flip = MAX_DIMS'(1) << i_rot;

    // Every level but the top one has its top bit inverted
    if (LEVEL > 0) begin : g_tflip
        assign w_top_flip = MAX_DIMS'(1) << (i_cfg.dims - DIM_CNT_W'(1));
    end else begin : g_no_tflip
        assign w_top_flip = '0;
    end
    assign w_adj = w_grp ^ w_top_flip;

    // Final bit = XOR of all index bits at or above it
    always_comb begin
        if (i_cfg.one_dim) begin
            w_fin = MAX_DIMS'(w_raw[0]);
        end else begin
            for (int j = 0; j < MAX_DIMS; j++) begin
                if (SUM_W'(j) < w_dims) begin
                    w_fin[j] = i_par ^ (^(w_adj >> j));
                end else begin
                    w_fin[j] = 1'b0;
                end
            end
        end
    end

    assign n_par = i_par ^ (^w_adj);
    assign n_idx = (i_idx << i_cfg.dims) | INDEX_W'(w_fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coords <= i_coords;
        if (w_active) begin
            r_rot  <= n_rot;
            r_flip <= n_flip;
            r_par  <= n_par;
            r_idx  <= n_idx;
        end else begin
            r_rot  <= i_rot;
            r_flip <= i_flip;
            r_par  <= i_par;
            r_idx  <= i_idx;
        end
    end

    assign o_valid  = r_valid;
    assign o_coords = r_coords;
    assign o_rot    = r_rot;
    assign o_flip   = r_flip;
    assign o_par    = r_par;
    assign o_idx    = r_idx;

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (SUM_W'(r_rot) < w_dims))
        else $error("rotation state out of range");

endmodule

`default_nettype wire

[rtl/hilbert_coords_to_index.sv]
// Top level: configuration registers, entry stage and one pipeline stage per
// curve level. Depends on hca_pkg, hca_prep and hca_level.
//
//   channel   handshake                     payload
//   -------   ---------------------------   ---------------------------------------
//   config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//   input     start / busy                  i_coord_x, i_coord_y, i_coord_z, i_coord_w
//   result    o_done (one-cycle strobe)     o_curve_index
//
// One item per cycle. Each item passes from start to o_done through one entry
// stage plus one stage per curve level, since the rotation state of a level
// depends on the level above it. Levels beyond bits_per_axis pass through.
// busy is high during reset and the cycle after; then items are always taken.
// Nothing stalls: results leave on o_done and the receiver cannot hold them.
`default_nettype none

module hilbert_coords_to_index import hca_pkg::*; #(
    parameter int MAX_DIMS = MAX_DIMS_DEF,
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [COORD_W-1:0]     i_coord_x,
    input  wire logic [COORD_W-1:0]     i_coord_y,
    input  wire logic [COORD_W-1:0]     i_coord_z,
    input  wire logic [COORD_W-1:0]     i_coord_w,
    output logic                        o_done,
    output logic [INDEX_W-1:0]          o_curve_index
);

    localparam int ROT_W   = $clog2(MAX_DIMS);
    localparam int CAP_W   = $clog2(INDEX_W + 1);
    localparam int LATENCY = MAX_BITS + 1;

    logic [DIM_REG_W-1:0]  r_dim_count;
    logic [BIT_REG_W-1:0]  r_bits_per_axis;
    logic                  r_busy;

    logic [DIM_CNT_W-1:0]  w_dims;
    logic [BIT_CNT_W-1:0]  w_bits_clamp;
    logic [BIT_CNT_W-1:0]  w_bits;
    logic [CAP_W-1:0]      w_cap;
    t_cfg                  w_cfg;
    logic                  w_accept;
    logic                  w_cfg_write;

    logic                                w_valid  [MAX_BITS+1];
    logic [MAX_DIMS-1:0][MAX_BITS-1:0]   w_coords [MAX_BITS+1];
    logic [ROT_W-1:0]                    w_rot    [MAX_BITS+1];
    logic [MAX_DIMS-1:0]                 w_flip   [MAX_BITS+1];
    logic                                w_par    [MAX_BITS+1];
    logic [INDEX_W-1:0]                  w_idx    [MAX_BITS+1];

    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count     <= DIM_RESET;
            r_bits_per_axis <= BITS_RESET;
        end else if (w_cfg_write) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_DIMENSION_COUNT: r_dim_count     <= i_cfg_data[DIM_REG_W-1:0];
                REG_BITS_PER_AXIS:   r_bits_per_axis <= i_cfg_data[BIT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // Effective dimension count and bits per axis
    always_comb begin
        if (r_dim_count == '0) begin
            w_dims = DIM_CNT_W'(1);
        end else if (DIM_CNT_W'(r_dim_count) > DIM_CNT_W'(MAX_DIMS)) begin
            w_dims = DIM_CNT_W'(MAX_DIMS);
        end else begin
            w_dims = DIM_CNT_W'(r_dim_count);
        end

        if (r_bits_per_axis == '0) begin
            w_bits_clamp = BIT_CNT_W'(1);
        end else if (BIT_CNT_W'(r_bits_per_axis) > BIT_CNT_W'(MAX_BITS)) begin
            w_bits_clamp = BIT_CNT_W'(MAX_BITS);
        end else begin
            w_bits_clamp = BIT_CNT_W'(r_bits_per_axis);
        end

        // Index must fit in INDEX_W bits
        unique case (w_dims)
            DIM_CNT_W'(2): w_cap = CAP_W'(INDEX_W / 2);
            DIM_CNT_W'(3): w_cap = CAP_W'(INDEX_W / 3);
            DIM_CNT_W'(4): w_cap = CAP_W'(INDEX_W / 4);
            DIM_CNT_W'(5): w_cap = CAP_W'(INDEX_W / 5);
            DIM_CNT_W'(6): w_cap = CAP_W'(INDEX_W / 6);
            DIM_CNT_W'(7): w_cap = CAP_W'(INDEX_W / 7);
            DIM_CNT_W'(8): w_cap = CAP_W'(INDEX_W / 8);
            default:       w_cap = CAP_W'(INDEX_W);
        endcase

        if (CAP_W'(w_bits_clamp) > w_cap) begin
            w_bits = BIT_CNT_W'(w_cap);
        end else begin
            w_bits = w_bits_clamp;
        end

        w_cfg.one_dim = (w_dims == DIM_CNT_W'(1));
        w_cfg.dims    = w_dims;
        w_cfg.bits    = w_bits;
    end

    hca_prep #(
        .MAX_DIMS (MAX_DIMS),
        .MAX_BITS (MAX_BITS)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_coord_z (i_coord_z),
        .i_coord_w (i_coord_w),
        .i_cfg     (w_cfg),
        .o_valid   (w_valid[0]),
        .o_coords  (w_coords[0])
    );

    // Walk state starts clear for every item
    assign w_rot[0]  = '0;
    assign w_flip[0] = '0;
    assign w_par[0]  = 1'b0;
    assign w_idx[0]  = '0;

    for (genvar k = 0; k < MAX_BITS; k++) begin : g_level
        hca_level #(
            .MAX_DIMS (MAX_DIMS),
            .MAX_BITS (MAX_BITS),
            .LEVEL    (k)
        ) u_level (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (w_cfg),
            .i_valid  (w_valid[k]),
            .i_coords (w_coords[k]),
            .i_rot    (w_rot[k]),
            .i_flip   (w_flip[k]),
            .i_par    (w_par[k]),
            .i_idx    (w_idx[k]),
            .o_valid  (w_valid[k+1]),
            .o_coords (w_coords[k+1]),
            .o_rot    (w_rot[k+1]),
            .o_flip   (w_flip[k+1]),
            .o_par    (w_par[k+1]),
            .o_idx    (w_idx[k+1])
        );
    end

    assign o_cfg_ready   = !r_busy;
    assign busy          = r_busy;
    assign o_done        = w_valid[MAX_BITS];
    assign o_curve_index = w_idx[MAX_BITS];

    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_done)
        else $error("accepted item did not come out");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, LATENCY))
        else $error("result without a matching item");

    a_one_dim_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && w_cfg.one_dim) |-> (o_curve_index[INDEX_W-1:MAX_BITS] == '0))
        else $error("one-axis index wider than the axis");

endmodule

`default_nettype wire

[sim/hca_checker.sv]
`timescale 1ns / 1ps
// Checker for hilbert_coords_to_index: watches the config, input and result
// channels, predicts each curve index and compares it. Depends on hca_pkg.

module hca_checker import hca_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [COORD_W-1:0]    i_coord_x,
    input  wire logic [COORD_W-1:0]    i_coord_y,
    input  wire logic [COORD_W-1:0]    i_coord_z,
    input  wire logic [COORD_W-1:0]    i_coord_w,
    input  wire logic                  i_done,
    input  wire logic [INDEX_W-1:0]    i_curve_index,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int PRINT_CAP = 50;

    logic [DIM_REG_W-1:0] dim_reg;
    logic [BIT_REG_W-1:0] bits_reg;
    logic [INDEX_W-1:0]   index_q[$];
    int                   item_no;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        item_no      = 0;
        dim_reg      = DIM_RESET;
        bits_reg     = BITS_RESET;
    end

    function automatic logic [63:0] low_bits(input int unsigned k);
        if (k >= 64)
            return '1;
        return (64'd1 << k) - 64'd1;
    endfunction

    function automatic logic [INDEX_W-1:0] hilbert_index(
        input logic [COORD_W-1:0]   cx,
        input logic [COORD_W-1:0]   cy,
        input logic [COORD_W-1:0]   cz,
        input logic [COORD_W-1:0]   cw,
        input logic [DIM_REG_W-1:0] dims_cfg,
        input logic [BIT_REG_W-1:0] bits_cfg
    );
        int unsigned n, b, total, rot, d, i;
        int          lv;
        logic [63:0] cmask, nmask, lowmask, ilv, idx, flip, grp, low, nth;
        logic [63:0] coord[4];
        n = dims_cfg;
        b = bits_cfg;
        if (n == 0) n = 1;
        if (n > MAX_DIMS_DEF) n = MAX_DIMS_DEF;
        if (b == 0) b = 1;
        if (b > MAX_BITS_DEF) b = MAX_BITS_DEF;
        if (n * b > 64) b = 64 / n;
        total = n * b;
        cmask = low_bits(b);
        coord[0] = 64'(cx) & cmask;
        coord[1] = 64'(cy) & cmask;
        coord[2] = 64'(cz) & cmask;
        coord[3] = 64'(cw) & cmask;
        if (n == 1)
            return coord[0];

        // bit i of axis d lands at i*n + d
        ilv = '0;
        for (i = 0; i < b; i++)
            for (d = 0; d < n; d++)
                ilv |= ((coord[d] >> i) & 64'd1) << (i * n + d);

        if (b > 1) begin
            nmask   = low_bits(n);
            lowmask = nmask >> 1;
            ilv     = ilv ^ (ilv >> n);
            idx     = '0;
            rot     = 0;
            flip    = '0;
            for (lv = int'(b) - 1; lv >= 0; lv--) begin
                grp = ((ilv >> (lv * n)) & nmask) ^ flip;
                if (rot != 0)
                    grp = (grp >> rot) | (grp << (n - rot));
                grp  = grp & nmask;
                idx  = (idx << n) | grp;
                flip = 64'd1 << rot;
                low  = grp & (~grp + 64'd1) & lowmask;
                while (low != 0) begin
                    low = low >> 1;
                    rot++;
                end
                rot++;
                if (rot >= n) rot -= n;
            end
            nth = '0;
            for (i = 0; i < b; i++)
                nth |= 64'd1 << (i * n);
            idx = idx ^ (nth >> 1);
        end else begin
            idx = ilv;
        end

        for (d = 1; d < total; d = d * 2)
            idx = idx ^ (idx >> d);
        return idx & low_bits(total);
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dim_reg  <= DIM_RESET;
            bits_reg <= BITS_RESET;
        end else begin
            if (i_done) begin
                if (index_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", i_curve_index));
                end else begin
                    if (i_curve_index !== index_q[0])
                        report_mismatch($sformatf("item %0d curve_index %h, want %h",
                            item_no, i_curve_index, index_q[0]));
                    void'(index_q.pop_front());
                    item_no++;
                end
            end
            if (i_start && !i_busy)
                index_q.push_back(hilbert_index(i_coord_x, i_coord_y, i_coord_z,
                                                i_coord_w, dim_reg, bits_reg));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_DIMENSION_COUNT)
                    dim_reg <= i_cfg_data[DIM_REG_W-1:0];
                else
                    bits_reg <= i_cfg_data[BIT_REG_W-1:0];
            end
            o_pending = index_q.size();
        end
    end

endmodule

[sim/tb_hilbert_coords_to_index.sv]
`timescale 1ns / 1ps
// Testbench top for hilbert_coords_to_index: clock, reset, config writes and
// point stimulus; verdict from hca_checker. Depends on hca_pkg and the RTL.

module tb_hilbert_coords_to_index;
    import hca_pkg::*;

    localparam int LATENCY     = MAX_BITS_DEF + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1250;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    i_coord_x = '0;
    logic [COORD_W-1:0]    i_coord_y = '0;
    logic [COORD_W-1:0]    i_coord_z = '0;
    logic [COORD_W-1:0]    i_coord_w = '0;
    logic                  o_done;
    logic [INDEX_W-1:0]    o_curve_index;

    int fail_count;
    int pending;
    int cycle_cnt = 0;
    int sent = 0;

    always #6 i_clk = ~i_clk;

    hilbert_coords_to_index dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_coord_w     (i_coord_w),
        .o_done        (o_done),
        .o_curve_index (o_curve_index)
    );

    hca_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (start),
        .i_busy        (busy),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_coord_w     (i_coord_w),
        .i_done        (o_done),
        .i_curve_index (o_curve_index),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** hilbert_coords_to_index: FAILED **");
            $finish;
        end
    end

    // Drop start and let the pipeline drain completely.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        wait (pending == 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = 5'($urandom);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] dims,
                              input logic [CFG_DATA_W-1:0] bits);
        drain();
        cfg_write(REG_DIMENSION_COUNT, dims);
        cfg_write(REG_BITS_PER_AXIS, bits);
    endtask

    // Present one item, hold until taken, then, if gap is nonzero, drop start and idle.
    task automatic send_item(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] w,
                             input int gap);
        @(negedge i_clk);
        start     = 1'b1;
        i_coord_x = x;
        i_coord_y = y;
        i_coord_z = z;
        i_coord_w = w;
        do @(posedge i_clk); while (busy);
        sent++;
        if (gap > 0) begin
            @(negedge i_clk);
            start     = 1'b0;
            i_coord_x = 16'($urandom);
            i_coord_y = 16'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic directed_setting(input logic [CFG_DATA_W-1:0] dims,
                                    input logic [CFG_DATA_W-1:0] bits);
        set_config(dims, bits);
        send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, $urandom_range(0, 2));
        send_item(16'hffff, 16'h0000, 16'haaaa, 16'h5555, $urandom_range(0, 2));
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int n_items, max_gap, i;
        logic [CFG_DATA_W-1:0] dims, bits;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // default setting first, including the all-zero point
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1);
        send_item(16'h8000, 16'h0001, 16'h0000, 16'h0000, 0);

        // one dimension, one bit per axis, full 64-bit index, zero and
        // oversize register values
        directed_setting(5'd1, 5'd16);
        directed_setting(5'd1, 5'd1);
        directed_setting(5'd4, 5'd1);
        directed_setting(5'd4, 5'd16);
        directed_setting(5'd3, 5'd7);
        directed_setting(5'd0, 5'd0);
        directed_setting(5'd31, 5'd31);
        directed_setting(5'd5, 5'd17);
        directed_setting(5'd2, 5'd2);

        while (sent < RAND_ITEMS + 21) begin
            if ($urandom_range(0, 3) == 0) begin
                dims = 5'($urandom);
                bits = 5'($urandom);
            end else begin
                dims = 5'($urandom_range(1, 4));
                bits = 5'($urandom_range(1, 16));
            end
            set_config(dims, bits);
            n_items = $urandom_range(20, 80);
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            for (i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 99) == 0)
                    drain();
                send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, max_gap));
            end
        end

        drain();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_count == 0)
            $display("** hilbert_coords_to_index: PASSED **");
        else
            $display("** hilbert_coords_to_index: FAILED **");
        $finish;
    end

endmodule
